[rtl/core/sm4_pkg.sv]
// shared types, constants and transform functions of the sm4 block cipher
package sm4_pkg;

    localparam int ROUNDS      = 32;
    localparam int IDX_W       = $clog2(ROUNDS);
    localparam int WORD_W      = 32;
    localparam int HALF_W      = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam idx_t     LAST_IDX         = idx_t'(ROUNDS - 1);
    localparam cfg_idx_t REG_KEY_HIGH     = cfg_idx_t'(0);
    localparam cfg_idx_t REG_KEY_LOW      = cfg_idx_t'(1);
    localparam cfg_idx_t REG_DECRYPT_MODE = cfg_idx_t'(2);

    localparam word_t FK0 = 32'ha3b1bac6;
    localparam word_t FK1 = 32'h56aa3350;
    localparam word_t FK2 = 32'h677d9197;
    localparam word_t FK3 = 32'hb27022dc;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_PREP,
        ST_ROUND,
        ST_DONE
    } sm4_state_t;

    typedef struct packed {
        logic load_block;
        logic load_key;
        logic expand_step;
        logic round_step;
        logic load_out;
        idx_t step_idx;
        idx_t rk_idx;
    } sm4_cmd_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    function automatic word_t rotl(input word_t v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic word_t tau(input word_t v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    // linear layer of the data rounds
    function automatic word_t l_data(input word_t b);
        return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    // linear layer of the key schedule
    function automatic word_t l_key(input word_t b);
        return b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

    // byte j of ck[i] is (4i+j)*7 mod 256
    function automatic word_t ck_word(input idx_t i);
        word_t      w;
        logic [6:0] n;
        w = '0;
        for (int j = 0; j < 4; j++)
        begin
            n = {i, 2'(j)};
            w = {w[23:0], 8'(n * 7)};
        end
        return w;
    endfunction

endpackage

[rtl/core/sm4_if.sv]
// item channels of the sm4 block cipher
interface sm4_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;

    modport source (output valid, output data_high, output data_low, input ready);
    modport sink (input valid, input data_high, input data_low, output ready);
endinterface

interface sm4_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;

    modport source (output valid, output result_high, output result_low, input ready);
    modport sink (input valid, input result_high, input result_low, output ready);
endinterface

[rtl/core/sm4_block_cipher.sv]
// sm4 block cipher top level, electronic codebook mode
// Each item is one 128-bit block; the result is the encrypted or decrypted block. With an
// expanded key schedule an item passes from acceptance to the output register through a
// prep state that starts the round key read, 32 rounds at one round per cycle through the
// shared s-box unit, and a load of the result once the output register is free. The first
// item after reset or after a write to key_high or key_low first runs the key expansion on
// the same unit. Round keys sit in a 32-entry store with a registered read port. The next
// item is accepted once the result has moved to the output register, while that result
// still waits to be taken. Write the key and decrypt_mode only while no item is in flight;
// decrypt_mode keeps the expanded keys.
module sm4_block_cipher (
    input  logic                           clk,
    input  logic                           rst_n,
    sm4_in_if.sink                         in_item,
    sm4_out_if.source                      out_item,
    input  logic                           cfg_we,
    input  sm4_pkg::cfg_idx_t              cfg_index,
    input  logic [sm4_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sm4_pkg::*;

    sm4_cmd_t cmd;

    sm4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_item.valid),
        .in_ready  (in_item.ready),
        .out_valid (out_item.valid),
        .out_ready (out_item.ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cmd       (cmd)
    );

    sm4_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .data_high   (in_item.data_high),
        .data_low    (in_item.data_low),
        .result_high (out_item.result_high),
        .result_low  (out_item.result_low)
    );

endmodule

[rtl/core/sm4_dp.sv]
// sm4 datapath: config registers, key schedule store, shared round unit, output register
module sm4_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sm4_pkg::sm4_cmd_t            cmd,
    input  logic                         cfg_we,
    input  sm4_pkg::cfg_idx_t            cfg_index,
    input  logic [sm4_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [sm4_pkg::HALF_W-1:0]   data_high,
    input  logic [sm4_pkg::HALF_W-1:0]   data_low,
    output logic [sm4_pkg::HALF_W-1:0]   result_high,
    output logic [sm4_pkg::HALF_W-1:0]   result_low
);
    import sm4_pkg::*;

    logic [HALF_W-1:0] key_high_reg;
    logic [HALF_W-1:0] key_low_reg;
    logic              decrypt_reg;

    word_t             rk_mem [ROUNDS];
    word_t             rk_rd_reg;
    word_t             x_reg [4];
    word_t             k_reg [4];
    logic [HALF_W-1:0] res_high_reg;
    logic [HALF_W-1:0] res_low_reg;

    idx_t  rd_addr;
    word_t tau_in;
    word_t b;
    word_t nk;
    word_t nx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            decrypt_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_HIGH:     key_high_reg <= cfg_data[HALF_W-1:0];
                REG_KEY_LOW:      key_low_reg  <= cfg_data[HALF_W-1:0];
                REG_DECRYPT_MODE: decrypt_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // reverse key order is the bitwise complement of the round index
    assign rd_addr = decrypt_reg ? ~cmd.rk_idx : cmd.rk_idx;

    always_comb
    begin
        if (cmd.expand_step)
        begin
            tau_in = k_reg[1] ^ k_reg[2] ^ k_reg[3] ^ ck_word(cmd.step_idx);
        end
        else
        begin
            tau_in = x_reg[1] ^ x_reg[2] ^ x_reg[3] ^ rk_rd_reg;
        end
    end

    assign b  = tau(tau_in);
    assign nk = k_reg[0] ^ l_key(b);
    assign nx = x_reg[0] ^ l_data(b);

    always_ff @(posedge clk)
    begin
        if (cmd.expand_step)
        begin
            rk_mem[cmd.step_idx] <= nk;
        end
        rk_rd_reg <= rk_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            k_reg[0] <= key_high_reg[63:32] ^ FK0;
            k_reg[1] <= key_high_reg[31:0] ^ FK1;
            k_reg[2] <= key_low_reg[63:32] ^ FK2;
            k_reg[3] <= key_low_reg[31:0] ^ FK3;
        end
        else if (cmd.expand_step)
        begin
            k_reg[0] <= k_reg[1];
            k_reg[1] <= k_reg[2];
            k_reg[2] <= k_reg[3];
            k_reg[3] <= nk;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_block)
        begin
            x_reg[0] <= data_high[63:32];
            x_reg[1] <= data_high[31:0];
            x_reg[2] <= data_low[63:32];
            x_reg[3] <= data_low[31:0];
        end
        else if (cmd.round_step)
        begin
            x_reg[0] <= x_reg[1];
            x_reg[1] <= x_reg[2];
            x_reg[2] <= x_reg[3];
            x_reg[3] <= nx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            res_high_reg <= {x_reg[3], x_reg[2]};
            res_low_reg  <= {x_reg[1], x_reg[0]};
        end
    end

    assign result_high = res_high_reg;
    assign result_low  = res_low_reg;

endmodule

[rtl/core/sm4_ctrl.sv]
// sm4 controller: key schedule and round sequencing, handshakes, key valid flag
module sm4_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic                cfg_we,
    input  sm4_pkg::cfg_idx_t   cfg_index,
    output sm4_pkg::sm4_cmd_t   cmd
);
    import sm4_pkg::*;

    sm4_state_t state_reg;
    sm4_state_t state_next;
    idx_t       cnt_reg;
    idx_t       cnt_next;
    logic       keys_valid_reg;
    logic       keys_valid_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    logic in_fire;
    logic key_wr;
    logic slot_free;

    assign in_fire   = in_valid && (state_reg == ST_IDLE);
    assign key_wr    = cfg_we && ((cfg_index == REG_KEY_HIGH) || (cfg_index == REG_KEY_LOW));
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            keys_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            keys_valid_reg <= keys_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_fire)
                begin
                    state_next = keys_valid_reg ? ST_PREP : ST_EXPAND;
                end
            end
            ST_EXPAND:
            begin
                cnt_next = cnt_reg + idx_t'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cnt_next   = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cnt_next = cnt_reg + idx_t'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.load_block  = in_fire;
        cmd.load_key    = in_fire && !keys_valid_reg;
        cmd.expand_step = (state_reg == ST_EXPAND);
        cmd.round_step  = (state_reg == ST_ROUND);
        cmd.load_out    = (state_reg == ST_DONE) && slot_free;
        cmd.step_idx    = cnt_reg;
        // read the key one round ahead to cover the registered read
        cmd.rk_idx      = (state_reg == ST_PREP) ? idx_t'(0) : cnt_reg + idx_t'(1);

        in_ready = (state_reg == ST_IDLE);

        priority if (key_wr)
        begin
            keys_valid_next = 1'b0;
        end
        else if ((state_reg == ST_EXPAND) && (cnt_reg == LAST_IDX))
        begin
            keys_valid_next = 1'b1;
        end
        else
        begin
            keys_valid_next = keys_valid_reg;
        end

        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_expand_needs_stale_keys: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXPAND) |-> !keys_valid_reg)
        else $error("key expansion while keys are valid");

    a_key_write_clears: assert property (@(posedge clk) disable iff (!rst_n)
        key_wr |=> !keys_valid_reg)
        else $error("key write did not clear key valid flag");

    a_stale_keys_expand: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !keys_valid_reg) |=> (state_reg == ST_EXPAND) && (cnt_reg == '0))
        else $error("item accepted with stale keys skipped expansion");

    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ROUND) && (cnt_reg != LAST_IDX))
        |=> (state_reg == ST_ROUND) && (cnt_reg == $past(cnt_reg) + idx_t'(1)))
        else $error("round sequence broken");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.load_out)
        else $error("pending result overwritten");
`endif

endmodule

[sim/sm4_result_checker.sv]
`timescale 1ns / 1ps
// checker that predicts each sm4 result block and compares it with the cipher output
module sm4_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    sm4_in_if                              in_ch,
    sm4_out_if                             out_ch,
    input  logic                           cfg_we,
    input  sm4_pkg::cfg_idx_t              cfg_index,
    input  logic [sm4_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             outstanding
);
    import sm4_pkg::*;

    typedef struct packed {
        logic [63:0] upper;
        logic [63:0] lower;
    } block_t;

    localparam logic [7:0] SUB_TABLE [256] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    localparam logic [31:0] KEY_MASK [4] = '{
        32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
    };

    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic        dec_mode;
    logic        sched_valid;
    logic [31:0] round_key_sched [ROUNDS];
    block_t      expected_blocks [$];
    int          mismatches = 0;
    int          waiting = 0;

    assign fail_count  = mismatches;
    assign outstanding = waiting;

    function automatic logic [31:0] rot_left(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] v);
        logic [31:0] w;
        for (int b = 0; b < 4; b++)
            w[8*b +: 8] = SUB_TABLE[v[8*b +: 8]];
        return w;
    endfunction

    // byte j of the round constant i is 7 * (4i + j), most significant first
    function automatic logic [31:0] round_const(input int i);
        logic [31:0] w;
        for (int j = 0; j < 4; j++)
            w[8*(3-j) +: 8] = 8'(28 * i + 7 * j);
        return w;
    endfunction

    function automatic void expand_round_keys();
        logic [31:0] k [4];
        logic [31:0] t;
        logic [31:0] nk;
        k[0] = key_hi[63:32] ^ KEY_MASK[0];
        k[1] = key_hi[31:0]  ^ KEY_MASK[1];
        k[2] = key_lo[63:32] ^ KEY_MASK[2];
        k[3] = key_lo[31:0]  ^ KEY_MASK[3];
        for (int i = 0; i < ROUNDS; i++)
        begin
            t  = sub_word(k[1] ^ k[2] ^ k[3] ^ round_const(i));
            nk = k[0] ^ t ^ rot_left(t, 13) ^ rot_left(t, 23);
            round_key_sched[i] = nk;
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = nk;
        end
        sched_valid = 1'b1;
    endfunction

    function automatic block_t sm4_crypt_block(input logic [63:0] hi, input logic [63:0] lo);
        logic [31:0] x [4];
        logic [31:0] rk;
        logic [31:0] t;
        logic [31:0] nx;
        block_t      r;
        x[0] = hi[63:32];
        x[1] = hi[31:0];
        x[2] = lo[63:32];
        x[3] = lo[31:0];
        for (int i = 0; i < ROUNDS; i++)
        begin
            rk = dec_mode ? round_key_sched[ROUNDS-1-i] : round_key_sched[i];
            t  = sub_word(x[1] ^ x[2] ^ x[3] ^ rk);
            nx = x[0] ^ t ^ rot_left(t, 2) ^ rot_left(t, 10) ^ rot_left(t, 18)
                 ^ rot_left(t, 24);
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = nx;
        end
        r.upper = {x[3], x[2]};
        r.lower = {x[1], x[0]};
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        block_t want;
        if (!rst_n)
        begin
            key_hi      = '0;
            key_lo      = '0;
            dec_mode    = 1'b0;
            sched_valid = 1'b0;
            expected_blocks.delete();
            waiting     = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_blocks.size() == 0)
                begin
                    $error("result item with no block pending: %h %h",
                           out_ch.result_high, out_ch.result_low);
                    mismatches++;
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (out_ch.result_high !== want.upper)
                    begin
                        $error("result_high mismatch: expected %h, got %h",
                               want.upper, out_ch.result_high);
                        mismatches++;
                    end
                    if (out_ch.result_low !== want.lower)
                    begin
                        $error("result_low mismatch: expected %h, got %h",
                               want.lower, out_ch.result_low);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_KEY_HIGH:
                    begin
                        key_hi      = cfg_data;
                        sched_valid = 1'b0;
                    end
                    REG_KEY_LOW:
                    begin
                        key_lo      = cfg_data;
                        sched_valid = 1'b0;
                    end
                    REG_DECRYPT_MODE:
                        dec_mode = cfg_data[0];
                    default:
                        ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (!sched_valid)
                    expand_round_keys();
                expected_blocks.push_back(sm4_crypt_block(in_ch.data_high, in_ch.data_low));
            end
            waiting = expected_blocks.size();
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// testbench top of the sm4 block cipher: stimulus, handshake pacing and verdict
module tb_top;
    import sm4_pkg::*;

    localparam int       CYCLE_LIMIT = 500000;
    localparam int       LONG_HOLD   = 300;
    localparam cfg_idx_t REG_UNUSED  = cfg_idx_t'(3);

    localparam logic [63:0] STD_KEY_HI    = 64'h0123456789abcdef;
    localparam logic [63:0] STD_KEY_LO    = 64'hfedcba9876543210;
    localparam logic [63:0] STD_CIPHER_HI = 64'h681edf34d206965e;
    localparam logic [63:0] STD_CIPHER_LO = 64'h86b3e94f536e4246;
    localparam logic [63:0] ALL_ONES      = 64'hffffffffffffffff;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int send_idle = 0;
    int recv_idle = 0;
    int hold_ask = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int fail_count;
    int outstanding;

    sm4_in_if  in_ch ();
    sm4_out_if out_ch ();

    sm4_block_cipher DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_ch),
        .out_item  (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sm4_result_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (hold_ask != hold_seen)
        begin
            hold_seen    <= hold_ask;
            hold_left    <= LONG_HOLD;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic logic [63:0] pick_value();
        case ($urandom_range(15))
            0:       return '0;
            1:       return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        if ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_high <= hi;
        in_ch.data_low  <= lo;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reconfigure();
        settle();
        if ($urandom_range(1))
            write_reg(REG_KEY_HIGH, pick_value());
        if ($urandom_range(1))
            write_reg(REG_KEY_LOW, pick_value());
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, pick_value());
        write_reg(REG_DECRYPT_MODE, {$urandom, $urandom});
    endtask

    task automatic run_phase(input int s_idle, input int r_idle, input int count);
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                reconfigure();
            if (i % 40 == 20)
                hold_ask++;
            send_block(pick_value(), pick_value());
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_KEY_HIGH;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_high = '0;
        in_ch.data_low  = '0;
        out_ch.ready    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // key left at its reset value
        send_block('0, '0);
        send_block(ALL_ONES, ALL_ONES);

        settle();
        write_reg(REG_KEY_HIGH, STD_KEY_HI);
        write_reg(REG_KEY_LOW, STD_KEY_LO);
        send_block(STD_KEY_HI, STD_KEY_LO);
        send_block('0, '0);
        send_block(ALL_ONES, ALL_ONES);
        send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);

        // mode switch keeps the expanded keys
        settle();
        write_reg(REG_DECRYPT_MODE, 64'h1);
        send_block(STD_CIPHER_HI, STD_CIPHER_LO);
        send_block(ALL_ONES, '0);

        // only bit 0 of the mode register counts
        settle();
        write_reg(REG_DECRYPT_MODE, 64'hfffffffffffffffe);
        send_block(STD_KEY_HI, STD_KEY_LO);

        settle();
        write_reg(REG_UNUSED, ALL_ONES);
        send_block(STD_KEY_HI, STD_KEY_LO);

        // new key while decrypting
        settle();
        write_reg(REG_DECRYPT_MODE, ALL_ONES);
        write_reg(REG_KEY_HIGH, ALL_ONES);
        write_reg(REG_KEY_LOW, ALL_ONES);
        send_block('0, '0);
        send_block(STD_KEY_HI, STD_KEY_LO);

        settle();
        write_reg(REG_KEY_LOW, '0);
        send_block(ALL_ONES, ALL_ONES);

        run_phase(27, 79, 170);
        run_phase(79, 27, 165);
        run_phase(0, 0, 165);

        settle();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/core/sm4_pkg.sv
rtl/core/sm4_if.sv
rtl/core/sm4_dp.sv
rtl/core/sm4_ctrl.sv
rtl/core/sm4_block_cipher.sv
sim/sm4_result_checker.sv
sim/tb_top.sv
